[hw/rtl/smsk_pkg.sv]
// Shared constants, codes and types of the shared-pool multi-stack block.
package smsk_pkg;

    localparam int POOL_DEPTH_DEF  = 64;
    localparam int MAX_STACKS_DEF  = 8;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int DATA_W   = 32;
    localparam int KIND_W   = 2;
    localparam int SID_W    = 3;
    localparam int CFG_W    = 4;
    localparam int STATUS_W = 2;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

    localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

    // Updates that the control side asks of the slot pool in the finishing cycle.
    typedef struct packed {
        logic push;
        logic pop;
    } pool_op_t;

endpackage

[hw/rtl/smsk_pool.sv]
// Slot pool: value and link memories, free-list head and fresh-slot fill count.
module smsk_pool
    import smsk_pkg::*;
#(
    parameter int POOL_DEPTH  = POOL_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int LINK_W      = $clog2(POOL_DEPTH + 1)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [LINK_W-1:0]             rd_addr,
    input  pool_op_t                      op,
    input  logic [LINK_W-1:0]             top_slot,
    input  logic signed [VALUE_WIDTH-1:0] wr_value,
    output logic [LINK_W-1:0]             free_head,
    output logic [LINK_W-1:0]             link_rd,
    output logic signed [VALUE_WIDTH-1:0] value_rd
);

    localparam int IDX_W = $clog2(POOL_DEPTH);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_DEPTH);

    logic signed [VALUE_WIDTH-1:0] value_mem [POOL_DEPTH];
    logic [LINK_W-1:0]             link_mem  [POOL_DEPTH];

    logic signed [VALUE_WIDTH-1:0] value_q_reg;
    logic [LINK_W-1:0]             link_q_reg;
    logic [LINK_W-1:0]             rd_addr_reg;
    logic [LINK_W-1:0]             free_head_reg;
    logic [LINK_W-1:0]             free_head_next;
    logic [LINK_W-1:0]             fill_reg;
    logic [LINK_W-1:0]             fill_next;
    logic                          link_we;
    logic [LINK_W-1:0]             link_wr_addr;
    logic [LINK_W-1:0]             link_wr_data;

    assign free_head = free_head_reg;
    assign value_rd  = value_q_reg;

    // Slots at or above the fill count were never linked by a request, so their link
    // is taken as the next slot in order instead of being read from the link memory.
    assign link_rd = (rd_addr_reg >= fill_reg) ? (rd_addr_reg + 1'b1) : link_q_reg;

    always_comb
    begin
        link_we        = op.push || op.pop;
        link_wr_addr   = op.push ? free_head_reg : top_slot;
        link_wr_data   = op.push ? top_slot : free_head_reg;
        free_head_next = free_head_reg;
        fill_next      = fill_reg;
        if (op.push)
        begin
            free_head_next = link_rd;
            if (free_head_reg == fill_reg)
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
        else if (op.pop)
        begin
            free_head_next = top_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en && (rd_addr != NIL))
        begin
            value_q_reg <= value_mem[rd_addr[IDX_W-1:0]];
            link_q_reg  <= link_mem[rd_addr[IDX_W-1:0]];
        end
        if (rd_en)
        begin
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            value_mem[free_head_reg[IDX_W-1:0]] <= wr_value;
        end
        if (link_we)
        begin
            link_mem[link_wr_addr[IDX_W-1:0]] <= link_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= '0;
            fill_reg      <= '0;
        end
        else
        begin
            free_head_reg <= free_head_next;
            fill_reg      <= fill_next;
        end
    end

endmodule

[hw/rtl/smsk_tops.sv]
// Top-of-stack pointer registers, one per stack, empty after reset.
module smsk_tops
    import smsk_pkg::*;
#(
    parameter int MAX_STACKS = MAX_STACKS_DEF,
    parameter int LINK_W     = 7,
    parameter int SIDX_W     = 3,
    parameter int POOL_DEPTH = POOL_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SIDX_W-1:0] sid,
    input  logic              we,
    input  logic [LINK_W-1:0] wr_top,
    output logic [LINK_W-1:0] top
);

    localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_DEPTH);

    logic [LINK_W-1:0] tops_reg [MAX_STACKS];

    assign top = tops_reg[sid];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STACKS; i++)
            begin
                tops_reg[i] <= NIL;
            end
        end
        else if (we)
        begin
            tops_reg[sid] <= wr_top;
        end
    end

endmodule

[hw/rtl/shared_pool_multi_stack.sv]
// Top level: several LIFO stacks sharing one slot pool, with request control.
//
//  channel   direction  handshake                 payload
//  request   in         start && !busy            kind, stack_id, push_value
//  result    out        done (one cycle, no hold) read_value, is_empty, status
//  config    in         cfg_write_en              cfg_write_data (active_stacks)
//
// A word cannot be taken in the read cycle of the last one: busy is high during the
// request's read cycle, while the top pointer (free head for a push)
// selects the slot whose link and value are read from the registered memories. A
// finishing cycle follows; its result is registered and strobed on done. Reset
// leaves every stack empty and the free list in slot order, kept by a fill count,
// so no clearing pass runs. The receiver cannot stall, so results never wait.
module shared_pool_multi_stack
    import smsk_pkg::*;
#(
    parameter int POOL_DEPTH  = POOL_DEPTH_DEF,
    parameter int MAX_STACKS  = MAX_STACKS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [KIND_W-1:0]          kind,
    input  logic [SID_W-1:0]           stack_id,
    input  logic signed [DATA_W-1:0]   push_value,
    output logic                       done,
    output logic signed [DATA_W-1:0]   read_value,
    output logic                       is_empty,
    output logic [STATUS_W-1:0]        status,
    input  logic                       cfg_write_en,
    input  logic [CFG_W-1:0]           cfg_write_data
);

    localparam int LINK_W = $clog2(POOL_DEPTH + 1);
    localparam int SIDX_W = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_DEPTH);

    logic                        a_valid_reg;
    logic                        b_valid_reg;
    logic [KIND_W-1:0]           kind_reg;
    logic [SID_W-1:0]            stack_id_reg;
    logic signed [DATA_W-1:0]    push_value_reg;
    logic [CFG_W-1:0]            active_stacks_reg;

    logic                        done_reg;
    logic signed [DATA_W-1:0]    read_value_reg;
    logic                        is_empty_reg;
    logic [STATUS_W-1:0]         status_reg;
    logic signed [DATA_W-1:0]    read_value_next;
    logic                        is_empty_next;
    logic [STATUS_W-1:0]         status_next;

    logic                        accept;
    logic                        bad;
    logic [SIDX_W-1:0]           sid_idx;
    logic [LINK_W-1:0]           top;
    logic [LINK_W-1:0]           free_head;
    logic [LINK_W-1:0]           link_rd;
    logic signed [VALUE_WIDTH-1:0] value_rd;
    logic signed [VALUE_WIDTH-1:0] wr_value;
    logic [LINK_W-1:0]           rd_addr;
    logic                        rd_en;
    logic                        top_empty;
    logic                        pool_full;
    pool_op_t                    op;
    logic                        tops_we;
    logic [LINK_W-1:0]           tops_wr;

    assign accept   = start && !busy;
    assign busy     = a_valid_reg;
    assign sid_idx  = SIDX_W'(stack_id_reg);
    assign wr_value = VALUE_WIDTH'(push_value_reg);

    assign bad = ({1'b0, stack_id_reg} >= active_stacks_reg)
              || (32'(stack_id_reg) >= 32'(MAX_STACKS));

    assign top_empty = (top == NIL);
    assign pool_full = (free_head == NIL);

    // A push follows the free-list head; every other kind reads the stack top.
    assign rd_addr = (kind_reg == KIND_PUSH) ? free_head : top;
    assign rd_en   = a_valid_reg && !bad;

    always_comb
    begin
        op.push         = 1'b0;
        op.pop          = 1'b0;
        read_value_next = '0;
        is_empty_next   = 1'b0;
        status_next     = ST_OK;
        if (bad)
        begin
            status_next = ST_BAD;
        end
        else
        begin
            case (kind_reg) inside
                KIND_PUSH:
                begin
                    if (pool_full)
                    begin
                        status_next   = ST_FULL;
                        is_empty_next = top_empty;
                    end
                    else
                    begin
                        op.push = b_valid_reg;
                    end
                end
                KIND_POP, KIND_PEEK:
                begin
                    if (top_empty)
                    begin
                        status_next   = ST_EMPTY;
                        is_empty_next = 1'b1;
                    end
                    else
                    begin
                        read_value_next = DATA_W'(value_rd);
                        if (kind_reg == KIND_POP)
                        begin
                            op.pop        = b_valid_reg;
                            is_empty_next = (link_rd == NIL);
                        end
                    end
                end
                default:
                begin
                    is_empty_next = top_empty;
                end
            endcase
        end
    end

    assign tops_we = op.push || op.pop;
    assign tops_wr = op.push ? free_head : link_rd;

    smsk_pool #(
        .POOL_DEPTH  (POOL_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .LINK_W      (LINK_W)
    ) u_pool (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .op        (op),
        .top_slot  (top),
        .wr_value  (wr_value),
        .free_head (free_head),
        .link_rd   (link_rd),
        .value_rd  (value_rd)
    );

    smsk_tops #(
        .MAX_STACKS (MAX_STACKS),
        .LINK_W     (LINK_W),
        .SIDX_W     (SIDX_W),
        .POOL_DEPTH (POOL_DEPTH)
    ) u_tops (
        .clk    (clk),
        .rst_n  (rst_n),
        .sid    (sid_idx),
        .we     (tops_we),
        .wr_top (tops_wr),
        .top    (top)
    );

    // The request word stays in place through its read and finishing cycles.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg       <= kind;
            stack_id_reg   <= stack_id;
            push_value_reg <= push_value;
        end
        if (b_valid_reg)
        begin
            read_value_reg <= read_value_next;
            is_empty_reg   <= is_empty_next;
            status_reg     <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg       <= 1'b0;
            b_valid_reg       <= 1'b0;
            done_reg          <= 1'b0;
            active_stacks_reg <= ACTIVE_RESET;
        end
        else
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
            done_reg    <= b_valid_reg;
            if (cfg_write_en)
            begin
                active_stacks_reg <= cfg_write_data;
            end
        end
    end

    assign done       = done_reg;
    assign read_value = read_value_reg;
    assign is_empty   = is_empty_reg;
    assign status     = status_reg;

    a_read_then_finish: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |=> b_valid_reg && !a_valid_reg)
        else $error("read cycle not followed by finishing cycle");

    a_phases_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(a_valid_reg && b_valid_reg))
        else $error("two requests in flight at once");

    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(b_valid_reg))
        else $error("result strobe without a finished request");

    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (read_value == '0))
        else $error("nonzero value with error status");

    a_single_update: assert property (@(posedge clk) disable iff (!rst_n)
        !(op.push && op.pop))
        else $error("push and pop updates in the same cycle");

endmodule
